// ===== src/expert_block_aligned_token_sort_macros.svh =====
// Assertion macros for the block-aligned token sort.
// Used by the top level only; expects a clock named clock and a reset named reset.
`ifndef EXPERT_BLOCK_ALIGNED_TOKEN_SORT_MACROS_SVH
`define EXPERT_BLOCK_ALIGNED_TOKEN_SORT_MACROS_SVH

// Same-cycle implication
`define ATSORT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define ATSORT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/atsort_pkg.sv =====
// Shared constants, payload types and state encoding of the block-aligned token sort.
// No dependencies.
package atsort_pkg;

   localparam int MAX_EXPERTS  = 64;
   localparam int BLOCK_TOKENS = 32;
   localparam int MAX_SLOTS    = 4096;
   localparam int MAX_PADDED   = MAX_SLOTS + MAX_EXPERTS * (BLOCK_TOKENS - 1);
   localparam int MAX_BLOCKS   = (MAX_PADDED + BLOCK_TOKENS - 1) / BLOCK_TOKENS;

   localparam int EXP_W  = $clog2(MAX_EXPERTS);
   localparam int NE_W   = 7;
   localparam int SLOT_W = $clog2(MAX_SLOTS);
   localparam int CNT_W  = 13;
   localparam int POS_W  = 13;
   localparam int BLK_W  = $clog2(MAX_BLOCKS + 1);
   localparam int OFS_W  = $clog2(BLOCK_TOKENS);
   localparam int FILL_W = 6;

   localparam logic REQ_APPEND   = 1'b0;
   localparam logic REQ_READ     = 1'b1;
   localparam logic KIND_SUMMARY = 1'b0;
   localparam logic KIND_READ    = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [EXP_W-1:0]  expert;
      logic              last;
      logic [POS_W-1:0]  position;
   } req_payload_type;

   typedef struct packed {
      logic              kind;
      logic [SLOT_W-1:0] token_index;
      logic              is_pad;
      logic [NE_W-1:0]   block_expert;
      logic [CNT_W-1:0]  block_start;
      logic [FILL_W-1:0] block_fill;
      logic [POS_W-1:0]  padded_total;
      logic              error;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_COUNT,
      ST_SC_RD,
      ST_SC_LD,
      ST_SC_BLK,
      ST_PLACE,
      ST_FIN,
      ST_READ
   } state_type;

endpackage

// ===== src/atsort_req_if.sv =====
// Request channel of the token sort: valid/ready handshake with a request payload.
// Depends on atsort_pkg.
interface atsort_req_if import atsort_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/atsort_rsp_if.sv =====
// Response channel of the token sort: valid/ready handshake with a response payload.
// Depends on atsort_pkg.
interface atsort_rsp_if import atsort_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/expert_block_aligned_token_sort.sv =====
// Block-aligned token sort: slot storage, count/scan/place passes and position reads.
// Depends on atsort_pkg, atsort_req_if, atsort_rsp_if and the assertion macro header.
//
// Usage: req carries transactions of two kinds. An append stores the expert of the
// next token slot (or, if the expert is beyond the limit or the slots are full, sets
// the error flag instead); it gives no response unless marked last. A last append
// closes the batch and starts the sort: a count clear over all experts, a count pass
// over the slots, a scan over the experts (reading each count and writing its
// blocks) and a placement pass. The summary response is registered once the
// placement pass ends and the output register is free.
// A read takes the sorted position and reads the block and sorted memories with
// registered read data; a new transaction is not taken until its response is
// registered. One transaction is worked on at a time; the request side is
// ready only while no pass or read is running.
// The response sits in an output register; if rsp is stalled the block holds the
// finished response and waits, while still taking a new transaction on req.
// csr_write_enable writes the expert limit, latched when a batch opens.
// Reset (synchronous, active high) closes the batch, clears counters and flags and
// sets the expert limit to 64; the memories are not cleared, but each sort opens with a pass that clears the counts.
`include "expert_block_aligned_token_sort_macros.svh"

module expert_block_aligned_token_sort import atsort_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_enable,
   input  logic [NE_W-1:0] csr_write_data,
   atsort_req_if.sink      req,
   atsort_rsp_if.source    rsp
);

   // memories
   logic [EXP_W-1:0]  slot_mem_ff [MAX_SLOTS];
   logic [CNT_W-1:0]  cnt_mem_ff  [MAX_EXPERTS];
   logic [POS_W-1:0]  pos_mem_ff  [MAX_EXPERTS];
   logic [SLOT_W-1:0] sort_mem_ff [MAX_PADDED];
   logic [NE_W-1:0]   bex_mem_ff  [MAX_BLOCKS];
   logic [CNT_W-1:0]  bst_mem_ff  [MAX_BLOCKS + 1];

   // registered read data
   logic [EXP_W-1:0]  slot_q_ff;
   logic [CNT_W-1:0]  cnt_q_ff;
   logic [POS_W-1:0]  pos_q_ff;
   logic [SLOT_W-1:0] sort_q_ff;
   logic [NE_W-1:0]   bex_q_ff;
   logic [CNT_W-1:0]  bst_q_ff;
   logic [CNT_W-1:0]  bst2_q_ff;

   // control state
   state_type         state_ff, state_in;
   logic [NE_W-1:0]   cfg_ne_ff;
   logic              batch_open_ff, batch_open_in;
   logic [NE_W-1:0]   open_ne_ff, open_ne_in;
   logic [CNT_W-1:0]  slot_count_ff, slot_count_in;
   logic              error_ff, error_in;
   logic [NE_W-1:0]   done_ne_ff, done_ne_in;
   logic [CNT_W-1:0]  done_real_ff, done_real_in;
   logic [POS_W-1:0]  total_ff, total_in;
   logic [EXP_W-1:0]  e_ff, e_in;
   logic [CNT_W-1:0]  i_ff, i_in;
   logic [BLK_W-1:0]  b_ff, b_in;
   logic [CNT_W-1:0]  run_ff, run_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [POS_W-1:0]  rd_pos_ff, rd_pos_in;

   // pass pipeline
   logic              s1_v_ff, s1_v_in;
   logic [SLOT_W-1:0] s1_i_ff;
   logic              s2_v_ff;
   logic [SLOT_W-1:0] s2_i_ff;
   logic [EXP_W-1:0]  s2_ex_ff;
   logic              wb_v_ff;
   logic [EXP_W-1:0]  wb_ex_ff;
   logic [CNT_W-1:0]  wb_val_ff;

   // output register
   logic              rsp_v_ff, rsp_v_in;
   rsp_payload_type   rsp_ff, rsp_in;

   // memory ports
   logic              slot_we;
   logic [SLOT_W-1:0] slot_wa;
   logic              cnt_we;
   logic [EXP_W-1:0]  cnt_wa, cnt_ra;
   logic [CNT_W-1:0]  cnt_wd;
   logic              pos_we;
   logic [EXP_W-1:0]  pos_wa;
   logic [POS_W-1:0]  pos_wd;
   logic              sort_we;
   logic [POS_W-1:0]  sort_wa, sort_ra;
   logic              bex_we;
   logic              bst_we;
   logic [BLK_W-1:0]  bst_wa, blk_ra, blk_ra2;
   logic [CNT_W-1:0]  bst_wd;

   // helpers
   logic              accept, is_append, keep, issue, out_free, pass_done;
   logic              last_acc;
   logic [NE_W-1:0]   ne_eff;
   logic [CNT_W-1:0]  cnt_eff;
   logic [CNT_W-1:0]  fwd_d, new_d, scan_c;
   logic [FILL_W-1:0] fill, rd_fill;
   logic              rd_in_range, rd_pad;

   assign req.ready   = (state_ff == ST_IDLE);
   assign rsp.valid   = rsp_v_ff;
   assign rsp.payload = rsp_ff;

   assign accept    = req.valid && req.ready;
   assign is_append = (req.payload.req_type == REQ_APPEND);
   assign out_free  = !rsp_v_ff || rsp.ready;
   assign last_acc  = accept && is_append && req.payload.last;

   // batch-open view of the latched settings
   assign ne_eff  = batch_open_ff ? open_ne_ff :
                    ((cfg_ne_ff > NE_W'(MAX_EXPERTS)) ? NE_W'(MAX_EXPERTS) : cfg_ne_ff);
   assign cnt_eff = batch_open_ff ? slot_count_ff : '0;
   assign keep    = ({1'b0, req.payload.expert} < ne_eff) && (cnt_eff < CNT_W'(MAX_SLOTS));

   // pass pipeline: issue, forward the last write-back, increment
   assign issue     = ((state_ff == ST_COUNT) || (state_ff == ST_PLACE)) && (i_ff < slot_count_ff);
   assign pass_done = (i_ff == slot_count_ff) && !s1_v_ff && !s2_v_ff;
   assign fwd_d     = (wb_v_ff && (wb_ex_ff == s2_ex_ff)) ? wb_val_ff :
                      ((state_ff == ST_PLACE) ? pos_q_ff : cnt_q_ff);
   assign new_d     = fwd_d + CNT_W'(1);

   // scan helpers
   assign scan_c = ({1'b0, e_ff} < open_ne_ff) ? cnt_q_ff : '0;
   assign fill   = (rem_ff >= CNT_W'(BLOCK_TOKENS)) ? FILL_W'(BLOCK_TOKENS) : rem_ff[FILL_W-1:0];

   // read answer
   assign rd_in_range = (rd_pos_ff < total_ff);
   assign rd_fill     = FILL_W'(bst2_q_ff - bst_q_ff);
   assign rd_pad      = ({1'b0, rd_pos_ff[OFS_W-1:0]} >= rd_fill);

   // memory addressing
   assign slot_we = accept && is_append && keep;
   assign slot_wa = cnt_eff[SLOT_W-1:0];
   assign cnt_ra  = (state_ff == ST_SC_RD) ? e_ff : slot_q_ff;
   assign sort_ra = (state_ff == ST_IDLE) ? req.payload.position : rd_pos_ff;
   assign blk_ra  = sort_ra[POS_W-1:OFS_W];
   assign blk_ra2 = blk_ra + BLK_W'(1);

   always_comb begin
      cnt_we  = 1'b0;
      cnt_wa  = e_ff;
      cnt_wd  = '0;
      pos_we  = 1'b0;
      pos_wa  = e_ff;
      pos_wd  = POS_W'({b_ff, {OFS_W{1'b0}}});
      sort_we = 1'b0;
      sort_wa = fwd_d;
      bex_we  = 1'b0;
      bst_we  = 1'b0;
      bst_wa  = b_ff + BLK_W'(1);
      bst_wd  = run_ff + CNT_W'(fill);
      unique case (state_ff)
         ST_CLEAR: begin
            cnt_we = 1'b1;
            bst_we = 1'b1;
            bst_wa = '0;
            bst_wd = '0;
         end
         ST_COUNT: begin
            cnt_we = s2_v_ff;
            cnt_wa = s2_ex_ff;
            cnt_wd = new_d;
         end
         ST_SC_LD: pos_we = 1'b1;
         ST_SC_BLK: begin
            bex_we = 1'b1;
            bst_we = 1'b1;
         end
         ST_PLACE: begin
            pos_we  = s2_v_ff;
            pos_wa  = s2_ex_ff;
            pos_wd  = new_d;
            sort_we = s2_v_ff;
         end
         default: ;
      endcase
   end

   // memories: write one address, read registered
   always_ff @(posedge clock) begin
      if (slot_we) slot_mem_ff[slot_wa] <= req.payload.expert;
      slot_q_ff <= slot_mem_ff[i_ff[SLOT_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) cnt_mem_ff[cnt_wa] <= cnt_wd;
      cnt_q_ff <= cnt_mem_ff[cnt_ra];
   end

   always_ff @(posedge clock) begin
      if (pos_we) pos_mem_ff[pos_wa] <= pos_wd;
      pos_q_ff <= pos_mem_ff[slot_q_ff];
   end

   always_ff @(posedge clock) begin
      if (sort_we) sort_mem_ff[sort_wa] <= s2_i_ff;
      sort_q_ff <= sort_mem_ff[sort_ra];
   end

   always_ff @(posedge clock) begin
      if (bex_we) bex_mem_ff[b_ff] <= NE_W'(e_ff);
      bex_q_ff <= bex_mem_ff[blk_ra];
   end

   always_ff @(posedge clock) begin
      if (bst_we) bst_mem_ff[bst_wa] <= bst_wd;
      bst_q_ff  <= bst_mem_ff[blk_ra];
      bst2_q_ff <= bst_mem_ff[blk_ra2];
   end

   // next state and sequencing
   always_comb begin
      state_in      = state_ff;
      batch_open_in = batch_open_ff;
      open_ne_in    = open_ne_ff;
      slot_count_in = slot_count_ff;
      error_in      = error_ff;
      done_ne_in    = done_ne_ff;
      done_real_in  = done_real_ff;
      total_in      = total_ff;
      e_in          = e_ff;
      i_in          = i_ff;
      b_in          = b_ff;
      run_in        = run_ff;
      rem_in        = rem_ff;
      rd_pos_in     = rd_pos_ff;
      s1_v_in       = issue;
      rsp_v_in      = rsp_v_ff && !rsp.ready;
      rsp_in        = rsp_ff;
      if (issue) i_in = i_ff + CNT_W'(1);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && is_append) begin
               batch_open_in = !req.payload.last;
               open_ne_in    = ne_eff;
               slot_count_in = cnt_eff + CNT_W'(keep);
               error_in      = (batch_open_ff ? error_ff : 1'b0) || !keep;
               e_in          = '0;
               b_in          = '0;
               run_in        = '0;
               if (req.payload.last) state_in = ST_CLEAR;
            end else if (accept) begin
               rd_pos_in = req.payload.position;
               state_in  = ST_READ;
            end
         end
         ST_CLEAR: begin
            e_in = e_ff + EXP_W'(1);
            i_in = '0;
            if (e_ff == EXP_W'(MAX_EXPERTS - 1)) state_in = ST_COUNT;
         end
         ST_COUNT: begin
            if (pass_done) begin
               e_in     = '0;
               state_in = ST_SC_RD;
            end
         end
         ST_SC_RD: state_in = ST_SC_LD;
         ST_SC_LD: begin
            rem_in = scan_c;
            if (scan_c != '0) begin
               state_in = ST_SC_BLK;
            end else if (e_ff == EXP_W'(MAX_EXPERTS - 1)) begin
               i_in     = '0;
               state_in = ST_PLACE;
            end else begin
               e_in     = e_ff + EXP_W'(1);
               state_in = ST_SC_RD;
            end
         end
         ST_SC_BLK: begin
            rem_in = rem_ff - CNT_W'(fill);
            b_in   = b_ff + BLK_W'(1);
            run_in = run_ff + CNT_W'(fill);
            if (rem_ff <= CNT_W'(BLOCK_TOKENS)) begin
               if (e_ff == EXP_W'(MAX_EXPERTS - 1)) begin
                  i_in     = '0;
                  state_in = ST_PLACE;
               end else begin
                  e_in     = e_ff + EXP_W'(1);
                  state_in = ST_SC_RD;
               end
            end
         end
         ST_PLACE: begin
            if (pass_done) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               total_in     = POS_W'({b_ff, {OFS_W{1'b0}}});
               done_ne_in   = open_ne_ff;
               done_real_in = slot_count_ff;
               rsp_v_in     = 1'b1;
               rsp_in       = '0;
               rsp_in.kind  = KIND_SUMMARY;
               rsp_in.padded_total = POS_W'({b_ff, {OFS_W{1'b0}}});
               rsp_in.error = error_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_READ: begin
            if (out_free) begin
               rsp_v_in            = 1'b1;
               rsp_in.kind         = KIND_READ;
               rsp_in.padded_total = total_ff;
               rsp_in.error        = error_ff;
               if (rd_in_range) begin
                  rsp_in.is_pad       = rd_pad;
                  rsp_in.token_index  = rd_pad ? '0 : sort_q_ff;
                  rsp_in.block_expert = bex_q_ff;
                  rsp_in.block_start  = bst_q_ff;
                  rsp_in.block_fill   = rd_fill;
               end else begin
                  rsp_in.is_pad       = 1'b1;
                  rsp_in.token_index  = '0;
                  rsp_in.block_expert = done_ne_ff;
                  rsp_in.block_start  = done_real_ff;
                  rsp_in.block_fill   = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state machine register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ne_ff     <= NE_W'(MAX_EXPERTS);
         batch_open_ff <= 1'b0;
         open_ne_ff    <= NE_W'(MAX_EXPERTS);
         slot_count_ff <= '0;
         error_ff      <= 1'b0;
         done_ne_ff    <= NE_W'(MAX_EXPERTS);
         done_real_ff  <= '0;
         total_ff      <= '0;
         e_ff          <= '0;
         i_ff          <= '0;
         b_ff          <= '0;
         run_ff        <= '0;
         rem_ff        <= '0;
         s1_v_ff       <= 1'b0;
         s2_v_ff       <= 1'b0;
         wb_v_ff       <= 1'b0;
         rsp_v_ff      <= 1'b0;
      end else begin
         if (csr_write_enable) cfg_ne_ff <= csr_write_data;
         batch_open_ff <= batch_open_in;
         open_ne_ff    <= open_ne_in;
         slot_count_ff <= slot_count_in;
         error_ff      <= error_in;
         done_ne_ff    <= done_ne_in;
         done_real_ff  <= done_real_in;
         total_ff      <= total_in;
         e_ff          <= e_in;
         i_ff          <= i_in;
         b_ff          <= b_in;
         run_ff        <= run_in;
         rem_ff        <= rem_in;
         s1_v_ff       <= s1_v_in;
         s2_v_ff       <= s1_v_ff;
         wb_v_ff       <= s2_v_ff;
         rsp_v_ff      <= rsp_v_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_pos_ff <= rd_pos_in;
      s1_i_ff   <= i_ff[SLOT_W-1:0];
      s2_i_ff   <= s1_i_ff;
      s2_ex_ff  <= slot_q_ff;
      wb_ex_ff  <= s2_ex_ff;
      wb_val_ff <= new_d;
      rsp_ff    <= rsp_in;
   end

   // checks
   `ATSORT_ASSERT_NOW(a_s2_follows_s1, s2_v_ff, $past(s1_v_ff), "pass stage 2 without stage 1")
   `ATSORT_ASSERT_NEXT(a_last_starts_sort, last_acc, state_ff == ST_CLEAR, "sort not started")
   `ATSORT_ASSERT_NOW(a_slot_bound, 1'b1, slot_count_ff <= CNT_W'(MAX_SLOTS), "slot overflow")

endmodule
